### design/uar_pkg.sv
// ----------------------------------------------------------------------------
// uar_pkg - shared types and constants for the ultrasonic array ranger
// Phase codes, status codes, sizing constants and the result record.
// ----------------------------------------------------------------------------
package uar_pkg;

  localparam int MAX_SENSORS = 4;
  localparam int US_PER_CM   = 58;

  // sensors addressable by the 2-bit sensor index
  localparam int SENSOR_CAP  = (MAX_SENSORS < 4) ? MAX_SENSORS : 4;

  localparam logic [2:0] SENSOR_CAP_3B = 3'(SENSOR_CAP);
  localparam logic [5:0] SUB_CM_LAST   = 6'(US_PER_CM - 1);
  localparam logic [10:0] PULSE_CM_MAX = 11'h7FF;

  // sweep phases
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_TRIG_LOW  = 3'd1;
  localparam logic [2:0] PH_TRIG_HIGH = 3'd2;
  localparam logic [2:0] PH_WAIT_RISE = 3'd3;
  localparam logic [2:0] PH_WAIT_FALL = 3'd4;
  localparam logic [2:0] PH_DELAY     = 3'd5;

  // measurement status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RISE_TO  = 2'd1;
  localparam logic [1:0] ST_FALL_TO  = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_NUM_SENSORS  = 2'd0;
  localparam logic [1:0] REG_INTER_DELAY  = 2'd1;
  localparam logic [1:0] REG_ECHO_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_TRIG_HIGH    = 2'd3;

  typedef struct packed {
    logic       sweep_done;
    logic [1:0] status;
    logic [10:0] range_cm;
    logic [1:0] result_sensor;
    logic       result_valid;
    logic       busy_res;
    logic [3:0] trigger_lines;
  } res_t;

endpackage

### design/ultrasonic_array_ranger_top.sv
// ----------------------------------------------------------------------------
// ultrasonic_array_ranger_top - multichannel ultrasonic ranger sweep controller
// Takes one tick/echo-sample beat per clock while the output keeps up and returns one result beat for it.
// ----------------------------------------------------------------------------
// Every input beat produces exactly one output beat. A beat is taken every
// clock while the output side keeps up. Each result is held in the single
// result register, which drives out_*, or in the skid entry on a stall. A
// two-entry output buffer (result register plus skid entry) lets one more
// beat be taken after out_tready drops. Configuration writes take effect on
// the next clock and should be made while no sweep is running.
module ultrasonic_array_ranger_top import uar_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [19:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // tick, start_req, echo_levels[3:0], pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // trigger_lines[3:0], busy_res, result_sensor[1:0],
                                  // range_cm[10:0], status[1:0], pad
  output logic        out_tuser,  // result_valid
  output logic        out_tlast   // sweep_done
);

  logic beat;
  res_t res;
  res_t out_res;

  assign beat = in_tvalid && in_tready;

  uar_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .beat        (beat),
    .tick        (in_tdata[0]),
    .start_req   (in_tdata[1]),
    .echo_levels (in_tdata[5:2]),
    .res         (res)
  );

  uar_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat      (beat),
    .res       (res),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {4'd0, out_res.status, out_res.range_cm, out_res.result_sensor,
                      out_res.busy_res, out_res.trigger_lines};
  assign out_tuser = out_res.result_valid;
  assign out_tlast = out_res.sweep_done;

endmodule

### design/uar_core.sv
// ----------------------------------------------------------------------------
// uar_core - sweep controller state and per-beat result logic
// Advances the sweep by one input beat and forms the matching result.
// ----------------------------------------------------------------------------
module uar_core import uar_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [19:0] cfg_wdata,
  input  logic        beat,
  input  logic        tick,
  input  logic        start_req,
  input  logic [3:0]  echo_levels,
  output res_t        res
);

  logic [2:0]  num_sensors_r;
  logic [19:0] inter_delay_r;
  logic [15:0] echo_timeout_r;
  logic [7:0]  trig_high_r;

  logic [2:0]  phase_r, phase_nxt;
  logic [1:0]  cur_r, cur_nxt;
  logic [19:0] cnt_r, cnt_nxt;
  logic [5:0]  sub_r, sub_nxt;
  logic [10:0] pcm_r, pcm_nxt;
  logic [10:0] dist_r [4];

  logic        echo;
  logic        done;
  logic        last;
  logic [1:0]  st;
  logic [19:0] cnt_inc;
  logic [2:0]  n_eff;
  logic [10:0] dist_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_sensors_r  <= 3'd4;
      inter_delay_r  <= 20'd60000;
      echo_timeout_r <= 16'd30000;
      trig_high_r    <= 8'd10;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_NUM_SENSORS:  num_sensors_r  <= cfg_wdata[2:0];
        REG_INTER_DELAY:  inter_delay_r  <= cfg_wdata;
        REG_ECHO_TIMEOUT: echo_timeout_r <= cfg_wdata[15:0];
        REG_TRIG_HIGH:    trig_high_r    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    n_eff = num_sensors_r;
    if (n_eff == 3'd0) n_eff = 3'd1;
    if (n_eff > SENSOR_CAP_3B) n_eff = SENSOR_CAP_3B;
  end

  assign echo    = echo_levels[cur_r];
  assign cnt_inc = cnt_r + 20'd1;

  always_comb begin
    phase_nxt = phase_r;
    cur_nxt   = cur_r;
    cnt_nxt   = cnt_r;
    sub_nxt   = sub_r;
    pcm_nxt   = pcm_r;
    done      = 1'b0;
    st        = ST_OK;
    last      = 1'b0;
    dist_out  = dist_r[cur_r];

    case (phase_r)
      PH_TRIG_LOW: begin
        if (tick) begin
          if (cnt_inc >= 20'd2) begin
            phase_nxt = PH_TRIG_HIGH;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
      end
      PH_TRIG_HIGH: begin
        if (tick) begin
          if (cnt_inc >= {12'd0, trig_high_r}) begin
            phase_nxt = PH_WAIT_RISE;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
      end
      PH_WAIT_RISE: begin
        if (echo) begin
          phase_nxt = PH_WAIT_FALL;
          cnt_nxt   = '0;
          sub_nxt   = '0;
          pcm_nxt   = '0;
        end else if (cnt_r >= {4'd0, echo_timeout_r}) begin
          done = 1'b1;
          st   = ST_RISE_TO;
        end else if (tick) begin
          cnt_nxt = cnt_inc;
        end
      end
      PH_WAIT_FALL: begin
        if (!echo) begin
          done = 1'b1;
          st   = (cnt_r == '0) ? ST_EMPTY : ST_OK;
        end else if (cnt_r >= {4'd0, echo_timeout_r}) begin
          done = 1'b1;
          st   = ST_FALL_TO;
        end else if (tick) begin
          cnt_nxt = cnt_inc;
          if (sub_r >= SUB_CM_LAST) begin
            sub_nxt = '0;
            if (pcm_r != PULSE_CM_MAX) pcm_nxt = pcm_r + 11'd1;
          end else begin
            sub_nxt = sub_r + 6'd1;
          end
        end
      end
      PH_DELAY: begin
        if (cnt_r >= inter_delay_r) begin
          phase_nxt = PH_TRIG_LOW;
          cnt_nxt   = '0;
        end else if (tick) begin
          cnt_nxt = cnt_inc;
        end
      end
      default: begin
        // idle, and any unused code falls back here
        phase_nxt = PH_IDLE;
        if (start_req) begin
          phase_nxt = PH_TRIG_LOW;
          cur_nxt   = '0;
          cnt_nxt   = '0;
        end
      end
    endcase

    if (done) begin
      last      = ({1'b0, cur_r} + 3'd1) >= n_eff;
      cnt_nxt   = '0;
      phase_nxt = last ? PH_IDLE : PH_DELAY;
      if (st == ST_OK) dist_out = pcm_r;
      if (!last) cur_nxt = cur_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cur_r   <= '0;
      cnt_r   <= '0;
      sub_r   <= '0;
      pcm_r   <= '0;
      for (int i = 0; i < 4; i++) begin
        dist_r[i] <= '0;
      end
    end else if (beat) begin
      phase_r <= phase_nxt;
      cur_r   <= cur_nxt;
      cnt_r   <= cnt_nxt;
      sub_r   <= sub_nxt;
      pcm_r   <= pcm_nxt;
      if (done) begin
        dist_r[cur_r] <= dist_out;
      end
    end
  end

  always_comb begin
    res               = '0;
    res.trigger_lines = (phase_nxt == PH_TRIG_HIGH) ? (4'd1 << cur_nxt) : 4'd0;
    res.busy_res      = (phase_nxt != PH_IDLE);
    res.result_valid  = done;
    if (done) begin
      res.result_sensor = cur_r;
      res.range_cm      = dist_out;
      res.status        = st;
      res.sweep_done    = last;
    end
  end

endmodule

### design/uar_skid.sv
// ----------------------------------------------------------------------------
// uar_skid - result register with one skid entry
// Holds results for the output channel so the input side keeps moving.
// ----------------------------------------------------------------------------
module uar_skid import uar_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic beat,
  input  res_t res,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic out_valid_r;
  logic skid_valid_r;
  res_t out_res_r;
  res_t skid_res_r;

  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (beat) begin
      // a beat is only taken with the skid entry empty
      if (!out_valid_r || out_ready) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid_r  <= skid_valid_r;
      skid_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (beat) begin
      if (!out_valid_r || out_ready) out_res_r <= res;
      else skid_res_r <= res;
    end else if (out_ready && skid_valid_r) begin
      out_res_r <= skid_res_r;
    end
  end

endmodule

### design/uar_checker.sv
// ----------------------------------------------------------------------------
// uar_checker - port-level checks for the ranger
// Watches the output channel of the top level over time.
// ----------------------------------------------------------------------------
module uar_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  // beats without a result carry zero result fields
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[23:5] == 19'd0 && !out_tlast)
    else $error("result fields set without result_valid");

  // the last result of a sweep already shows the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> !out_tdata[4] && out_tdata[3:0] == 4'd0)
    else $error("busy or trigger on sweep end");

  // at most one trigger, and only during a sweep
  a_trig: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0(out_tdata[3:0]) && (out_tdata[3:0] == 4'd0 || out_tdata[4]))
    else $error("bad trigger drive");

endmodule

bind ultrasonic_array_ranger_top uar_checker u_uar_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
